>>> rtl/core/lpfi_pkg.sv
// shared types and constants for the linear probe find-or-insert block
`default_nettype none

package lpfi_pkg;

	// fixed field widths
	localparam int KEY_W    = 31;
	localparam int STATUS_W = 2;
	localparam int PROBES_W = 5;

	// table depth default, handed down from the top level
	localparam int TABLE_SIZE_DEF = 16;

	// probe limit after reset
	localparam logic [PROBES_W-1:0] PROBES_RESET = 5'd5;

	// home slot reduction: key bits taken MSB first, MOD_BITS per cycle
	localparam int MOD_BITS  = 8;
	localparam int MOD_STEPS = (KEY_W + MOD_BITS - 1) / MOD_BITS;
	localparam int KEY_PAD_W = MOD_BITS * MOD_STEPS;
	localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

	typedef logic [STATUS_W-1:0] status_t;

	// result codes
	localparam status_t ST_INSERTED = 2'd0;
	localparam status_t ST_FOUND    = 2'd1;
	localparam status_t ST_FULL     = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic clear;
		logic load;
		logic mod_step;
		logic probe;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic mod_last;
		logic done;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/core/lpfi_ctrl.sv
// controller state machine: sequencing of clear, reduction, probing and result hand-off
`default_nettype none

module lpfi_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output lpfi_pkg::cmd_t  cmd,
	input  lpfi_pkg::sts_t  sts
);
	import lpfi_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	// output register can take a new result
	assign out_free = !rsp_valid_q || !rsp_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTH
	// an accepted request always starts the home slot reduction
	a_load_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_MOD))
		else $error("request accepted without entering reduction");

	// a result only appears after a search has finished
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the hand-off state");

	// a finished search with a free output register hands off at once
	a_done_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !rsp_valid_q) |=> (rsp_valid_q && state_q == ST_IDLE))
		else $error("result hand-off delayed with free output register");
`endif

endmodule

`default_nettype wire

>>> rtl/core/lpfi_datapath.sv
// datapath: probe limit register, home slot reduction, slot store and probe compare
`default_nettype none

module lpfi_datapath #(
	parameter int TABLE_SIZE = lpfi_pkg::TABLE_SIZE_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  lpfi_pkg::cmd_t                 cmd,
	output lpfi_pkg::sts_t                 sts,
	input  wire [lpfi_pkg::KEY_W-1:0]      key,
	input  wire                            cfg_we,
	input  wire [lpfi_pkg::PROBES_W-1:0]   cfg_data,
	output lpfi_pkg::status_t              status
);
	import lpfi_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam logic [AW:0]   TS_EXT  = (AW+1)'(TABLE_SIZE);
	localparam logic [AW-1:0] SLOT_LAST = AW'(TABLE_SIZE - 1);

	// slot store
	logic [KEY_W-1:0]     mem [TABLE_SIZE];

	logic [PROBES_W-1:0]  max_probes_q;
	logic [KEY_W-1:0]     key_q;
	logic [KEY_PAD_W-1:0] key_sh_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [AW-1:0]        slot_q;
	logic [PROBES_W-1:0]  iss_q;
	logic [PROBES_W-1:0]  cmp_q;
	logic                 rd_vld_s1;
	logic [KEY_W-1:0]     rd_data_s1;
	logic [AW-1:0]        rd_slot_s1;
	status_t              res_q;
	status_t              status_q;

	logic [AW-1:0]        rem_d;
	logic [AW-1:0]        slot_next;
	logic                 issue;
	logic                 lim_zero;
	logic                 slot_empty;
	logic                 slot_match;
	logic                 cmp_last;
	status_t              res_d;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [KEY_W-1:0]     mem_wd;

	// probe limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_probes_q <= PROBES_RESET;
		end else if (cfg_we) begin
			max_probes_q <= cfg_data;
		end
	end

	// remainder step: MOD_BITS restoring shift-subtract steps
	always_comb begin
		logic [AW-1:0] r;
		logic [AW:0]   t;
		r = slot_q;
		t = '0;
		for (int i = 0; i < MOD_BITS; i++) begin
			t = {r, key_sh_q[KEY_PAD_W-1-i]};
			if (t >= TS_EXT) begin
				t = t - TS_EXT;
			end
			r = t[AW-1:0];
		end
		rem_d = r;
	end

	// linear probe wrap
	assign slot_next = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

	// probe decision
	always_comb begin
		lim_zero   = (max_probes_q == '0);
		issue      = cmd.probe && (iss_q < max_probes_q);
		slot_empty = (rd_data_s1 == '0);
		slot_match = (rd_data_s1 == key_q);
		cmp_last   = (((PROBES_W+1)'(cmp_q) + 1'b1) == (PROBES_W+1)'(max_probes_q));
		if (rd_vld_s1 && slot_empty) begin
			res_d = ST_INSERTED;
		end else if (rd_vld_s1 && slot_match) begin
			res_d = ST_FOUND;
		end else begin
			res_d = ST_FULL;
		end
		sts.done     = cmd.probe && (lim_zero ||
			(rd_vld_s1 && (slot_empty || slot_match || cmp_last)));
		sts.clr_last = (slot_q == SLOT_LAST);
		sts.mod_last = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
	end

	// store write port: clearing pass or insert
	always_comb begin
		mem_we = cmd.clear || (cmd.probe && rd_vld_s1 && slot_empty);
		mem_wa = cmd.clear ? slot_q : rd_slot_s1;
		mem_wd = cmd.clear ? '0 : key_q;
	end

	// slot store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rd_data_s1 <= mem[slot_q];
		end
	end

	// slot pointer, reduction and probe counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			mod_cnt_q <= '0;
			iss_q     <= '0;
			cmp_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clear) begin
				slot_q <= slot_next;
			end else if (cmd.load) begin
				slot_q <= '0;
			end else if (cmd.mod_step) begin
				slot_q <= rem_d;
			end else if (issue) begin
				slot_q <= slot_next;
			end

			if (cmd.load) begin
				mod_cnt_q <= '0;
			end else if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end

			if (cmd.load) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end

			if (cmd.load) begin
				cmp_q <= '0;
			end else if (cmd.probe && rd_vld_s1) begin
				cmp_q <= cmp_q + 1'b1;
			end

			rd_vld_s1 <= issue;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= key;
			key_sh_q <= {{(KEY_PAD_W-KEY_W){1'b0}}, key};
		end else if (cmd.mod_step) begin
			key_sh_q <= key_sh_q << MOD_BITS;
		end
		if (issue) begin
			rd_slot_s1 <= slot_q;
		end
		if (sts.done) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			status_q <= res_q;
		end
	end

	assign status = status_q;

`ifndef SYNTH
	// the store is only written during a search when the key is inserted
	a_probe_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.probe && mem_we) |-> (sts.done && res_d == ST_INSERTED))
		else $error("store written during search without insert");

	// read data in flight always belongs to a read not yet compared
	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (cmp_q < iss_q))
		else $error("compare without an outstanding read");

	// reads never go past the probe limit
	a_issue_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> (iss_q <= max_probes_q))
		else $error("more reads issued than the probe limit");
`endif

endmodule

`default_nettype wire

>>> rtl/core/linear_probe_find_or_insert.sv
// top level of the linear probe find-or-insert set
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------
//   request  | req_valid / req_stall | key [30:0]
//   result   | rsp_valid / rsp_stall | status [1:0]
//   config   | cfg_valid / cfg_ready | max_probes [4:0]
//
// one request at a time: taken in the idle state, then home slot reduction
// over MOD_STEPS key chunks, then k probes through the single store read
// port with k up to max_probes, then the hand-off of the result.
// after reset a clearing pass writes empty to each slot while requests
// are stalled; config writes are always taken.
// a finished result waits in the output register while the next request runs;
// a search that finishes while that register is still held waits for it.
`default_nettype none

module linear_probe_find_or_insert #(
	parameter int TABLE_SIZE = lpfi_pkg::TABLE_SIZE_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            req_valid,
	output logic                           req_stall,
	input  wire [lpfi_pkg::KEY_W-1:0]      key,
	output logic                           rsp_valid,
	input  wire                            rsp_stall,
	output lpfi_pkg::status_t              status,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [lpfi_pkg::PROBES_W-1:0]   max_probes
);
	import lpfi_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	// register writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencing
	lpfi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// store and arithmetic
	lpfi_datapath #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.key      (key),
		.cfg_we   (cfg_we),
		.cfg_data (max_probes),
		.status   (status)
	);

endmodule

`default_nettype wire
